### design/bpq_pkg.sv
// Package for the bucketed priority queue: item structs, chain link struct,
// opcode and status codes. No dependencies.
`default_nettype none

package bpq_pkg;

   localparam logic [1:0] OP_PUSH     = 2'd0;
   localparam logic [1:0] OP_POP_FWD  = 2'd1;
   localparam logic [1:0] OP_POP_REV  = 2'd2;
   localparam logic [1:0] OP_RESERVED = 2'd3;

   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_BADPRI = 2'd1;
   localparam logic [1:0] ST_EMPTY  = 2'd2;
   localparam logic [1:0] ST_FULL   = 2'd3;

   typedef struct packed {
      logic [1:0]         op;
      logic signed [31:0] item_value;
      logic [7:0]         priority_level;
   } req_type;

   typedef struct packed {
      logic signed [31:0] popped_value;
      logic [1:0]         status;
      logic [7:0]         total_count;
   } rsp_type;

   // one hop of the cell chain
   typedef struct packed {
      logic        vld;    // request in this stage
      logic        pend;   // no cell has acted on it yet
      logic        push;   // push (else pop)
      logic        full;   // push hit a full level
      logic [7:0]  level;  // target level of a push
      logic [31:0] data;   // push value, or popped value once done
   } link_type;

endpackage

`default_nettype wire

### design/bucketed_priority_queue.sv
// Invalid priority, reserved op or pop of an empty queue: the result is loaded
// in IDLE and goes straight to DONE. Push and pop: the item walks the whole
// row of level cells, one cell per cycle, and RUN loads the result. One item at a
// time: req_stall is held outside IDLE, and DONE waits while rsp_stall holds the
// previous response. Reset clears pointers, fill counts and the total;
// entry storage is not cleared and needs no clearing pass.
`default_nettype none

module bucketed_priority_queue
   import bpq_pkg::*;
#(
   parameter int LEVELS = 8,
   parameter int DEPTH  = 16
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_item,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_item
);

   localparam int TW = $clog2(LEVELS * DEPTH + 1);

   typedef enum logic [1:0] {IDLE, RUN, DONE} state_type;

   state_type     state_ff;
   logic          rsp_valid_ff;
   rsp_type       rsp_item_ff;
   rsp_type       res_ff, end_res;
   logic [TW-1:0] total_ff, total_in;
   link_type      fwd_start_ff, bwd_start_ff;
   link_type      fwd_link [LEVELS];
   link_type      bwd_link [LEVELS];
   link_type      end_link;
   logic          end_vld, bad_pri;
   logic [TW+7:0] cur_wide, nxt_wide;

   for (genvar i = 0; i < LEVELS; i++) begin : g_cell
      link_type fin, bin;
      if (i == 0) begin : g_f0
         assign fin = fwd_start_ff;
      end else begin : g_fn
         assign fin = fwd_link[i-1];
      end
      if (i == LEVELS - 1) begin : g_bl
         assign bin = bwd_start_ff;
      end else begin : g_bn
         assign bin = bwd_link[i+1];
      end
      bpq_cell #(.IDX(i), .DEPTH(DEPTH)) u_cell (
         .clock   (clock),
         .reset   (reset),
         .fwd_in  (fin),
         .bwd_in  (bin),
         .fwd_out (fwd_link[i]),
         .bwd_out (bwd_link[i])
      );
   end

   assign bad_pri  = ({1'b0, req_item.priority_level} >= 9'(LEVELS));
   assign end_vld  = fwd_link[LEVELS-1].vld || bwd_link[0].vld;
   assign end_link = fwd_link[LEVELS-1].vld ? fwd_link[LEVELS-1] : bwd_link[0];
   assign cur_wide = {8'b0, total_ff};
   assign nxt_wide = {8'b0, total_in};

   always_comb begin
      total_in = total_ff;
      end_res  = '0;
      if (end_link.push) begin
         if (end_link.full) begin
            end_res.status = ST_FULL;
         end else begin
            end_res.status = ST_OK;
            total_in       = total_ff + 1'b1;
         end
      end else begin
         end_res.status       = ST_OK;
         end_res.popped_value = end_link.data;
         total_in             = total_ff - 1'b1;
      end
      end_res.total_count = nxt_wide[7:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= IDLE;
         rsp_valid_ff     <= 1'b0;
         total_ff         <= '0;
         fwd_start_ff.vld <= 1'b0;
         bwd_start_ff.vld <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall && state_ff != DONE) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            IDLE: begin
               if (req_valid) begin
                  priority if (req_item.op == OP_PUSH && bad_pri) begin
                     res_ff   <= '{32'sd0, ST_BADPRI, cur_wide[7:0]};
                     state_ff <= DONE;
                  end else if (req_item.op == OP_PUSH) begin
                     fwd_start_ff <= '{1'b1, 1'b1, 1'b1, 1'b0, req_item.priority_level,
                                       req_item.item_value};
                     state_ff     <= RUN;
                  end else if (req_item.op == OP_RESERVED) begin
                     res_ff   <= '{32'sd0, ST_BADPRI, cur_wide[7:0]};
                     state_ff <= DONE;
                  end else if (total_ff == '0) begin
                     res_ff   <= '{32'sd0, ST_EMPTY, cur_wide[7:0]};
                     state_ff <= DONE;
                  end else if (req_item.op == OP_POP_FWD) begin
                     fwd_start_ff <= '{1'b1, 1'b1, 1'b0, 1'b0, 8'd0, 32'd0};
                     state_ff     <= RUN;
                  end else begin
                     bwd_start_ff <= '{1'b1, 1'b1, 1'b0, 1'b0, 8'd0, 32'd0};
                     state_ff     <= RUN;
                  end
               end
            end
            RUN: begin
               fwd_start_ff.vld <= 1'b0;
               bwd_start_ff.vld <= 1'b0;
               if (end_vld) begin
                  res_ff   <= end_res;
                  total_ff <= total_in;
                  state_ff <= DONE;
               end
            end
            DONE: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_item_ff  <= res_ff;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= IDLE;
               end
            end
            default: begin
               state_ff <= IDLE;
            end
         endcase
      end
   end

   assign req_stall = (state_ff != IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

`default_nettype wire

### design/bpq_cell.sv
// One priority level of the queue: a ring buffer of DEPTH entries plus the
// registered forward and reverse chain stages. Depends on bpq_pkg.
`default_nettype none

module bpq_cell
   import bpq_pkg::*;
#(
   parameter int IDX   = 0,
   parameter int DEPTH = 16
) (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire link_type fwd_in,
   input  wire link_type bwd_in,
   output link_type      fwd_out,
   output link_type      bwd_out
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int FW = $clog2(DEPTH + 1);
   localparam int LW = $bits(link_type);

   logic [31:0]   mem [DEPTH];
   logic [PW-1:0] head_ff, head_in;
   logic [PW-1:0] tail_ff, tail_in;
   logic [FW-1:0] fill_ff, fill_in;
   link_type      fwd_ff, fwd_in_nx;
   link_type      bwd_ff, bwd_in_nx;

   logic match_push, is_full, nonempty, do_push, fwd_pop, bwd_pop, do_pop;

   assign is_full    = (fill_ff == FW'(DEPTH));
   assign nonempty   = (fill_ff != '0);
   assign match_push = fwd_in.vld && fwd_in.pend && fwd_in.push && (fwd_in.level == 8'(IDX));
   assign do_push    = match_push && !is_full;
   assign fwd_pop    = fwd_in.vld && fwd_in.pend && !fwd_in.push && nonempty;
   assign bwd_pop    = bwd_in.vld && bwd_in.pend && nonempty;
   assign do_pop     = fwd_pop || bwd_pop;

   always_comb begin
      head_in = head_ff;
      tail_in = tail_ff;
      fill_in = fill_ff;
      if (do_push) begin
         tail_in = (tail_ff == PW'(DEPTH - 1)) ? '0 : tail_ff + 1'b1;
         fill_in = fill_ff + 1'b1;
      end else if (do_pop) begin
         head_in = (head_ff == PW'(DEPTH - 1)) ? '0 : head_ff + 1'b1;
         fill_in = fill_ff - 1'b1;
      end
   end

   always_comb begin
      fwd_in_nx      = fwd_in;
      fwd_in_nx.pend = fwd_in.pend && !(match_push || fwd_pop);
      fwd_in_nx.full = fwd_in.full || (match_push && is_full);
      bwd_in_nx      = bwd_in;
      bwd_in_nx.pend = bwd_in.pend && !bwd_pop;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff    <= '0;
         tail_ff    <= '0;
         fill_ff    <= '0;
         fwd_ff.vld <= 1'b0;
         bwd_ff.vld <= 1'b0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         fill_ff <= fill_in;
         fwd_ff  <= fwd_pop ? link_type'({fwd_in_nx[LW-1:32], mem[head_ff]}) : fwd_in_nx;
         bwd_ff  <= bwd_pop ? link_type'({bwd_in_nx[LW-1:32], mem[head_ff]}) : bwd_in_nx;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[tail_ff] <= fwd_in.data;
      end
   end

   assign fwd_out = fwd_ff;
   assign bwd_out = bwd_ff;

endmodule

`default_nettype wire

### bench/bucketed_priority_queue_tb.sv
// Testbench for bucketed_priority_queue: a directed table, then random push/pop
// segments, every response checked against the table's expected value or an in-bench model of the level FIFOs.
// Depends on bpq_pkg and the bucketed_priority_queue RTL.
`timescale 1ns / 1ps

module bucketed_priority_queue_tb
   import bpq_pkg::*;
();

   localparam int LEVELS = 8;
   localparam int DEPTH  = 16;
   localparam int RANDOM_ITEMS = 1800;
   localparam int DRAIN_CYCLES = 4 * (LEVELS + 2);

   typedef struct {
      req_type item;
      bit      typed;
      rsp_type want;
   } plan_entry_type;

   typedef struct {
      logic [1:0]  op;
      logic [31:0] value;
      logic [7:0]  level;
      int          reps;
      bit          typed;
      rsp_type     want;
   } dir_row_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_item = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_item;

   bucketed_priority_queue #(.LEVELS(LEVELS), .DEPTH(DEPTH)) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_item (req_item),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_item (rsp_item)
   );

   // model of the level rings
   logic [31:0] ring_mem [LEVELS][DEPTH];
   int          ring_head [LEVELS];
   int          ring_tail [LEVELS];
   int          ring_fill [LEVELS];
   int          held_total = 0;

   int n_ok_pops = 0, n_full = 0, n_badpri = 0, n_empty = 0, peak_total = 0;

   dir_row_type    dir_rows[$];
   plan_entry_type pending_reqs[$];
   rsp_type        expected_rsps[$];

   int      n_planned = 0;
   int      n_sent = 0;
   int      n_rcvd = 0;
   int      errors = 0;
   int      hold_left = 0;
   bit      cur_typed = 1'b0;
   rsp_type cur_want;
   rsp_type model_rsp;
   rsp_type got_want;

   function automatic rsp_type serve_request(req_type r);
      rsp_type o;
      int      lvl;
      int      k;
      int      cand;
      o.popped_value = '0;
      o.status = ST_OK;
      lvl = -1;
      case (r.op)
         OP_PUSH: begin
            if (r.priority_level >= LEVELS) begin
               o.status = ST_BADPRI;
               n_badpri++;
            end else if (ring_fill[r.priority_level] >= DEPTH) begin
               o.status = ST_FULL;
               n_full++;
            end else begin
               lvl = int'(r.priority_level);
               ring_mem[lvl][ring_tail[lvl]] = r.item_value;
               ring_tail[lvl] = (ring_tail[lvl] + 1 >= DEPTH) ? 0 : ring_tail[lvl] + 1;
               ring_fill[lvl]++;
               held_total++;
               if (held_total > peak_total) peak_total = held_total;
            end
         end
         OP_POP_FWD, OP_POP_REV: begin
            for (k = 0; k < LEVELS; k++) begin
               cand = (r.op == OP_POP_FWD) ? k : LEVELS - 1 - k;
               if (lvl < 0 && ring_fill[cand] != 0) lvl = cand;
            end
            if (lvl < 0) begin
               o.status = ST_EMPTY;
               n_empty++;
            end else begin
               o.popped_value = ring_mem[lvl][ring_head[lvl]];
               ring_head[lvl] = (ring_head[lvl] + 1 >= DEPTH) ? 0 : ring_head[lvl] + 1;
               ring_fill[lvl]--;
               held_total--;
               n_ok_pops++;
            end
         end
         default: begin
            o.status = ST_BADPRI;
            n_badpri++;
         end
      endcase
      o.total_count = 8'(held_total);
      return o;
   endfunction

   task automatic add_row(logic [1:0] op, logic [31:0] value, logic [7:0] level, int reps,
                          bit typed, logic [31:0] wv, logic [1:0] ws, logic [7:0] wc);
      dir_row_type row;
      row.op = op;
      row.value = value;
      row.level = level;
      row.reps = reps;
      row.typed = typed;
      row.want.popped_value = wv;
      row.want.status = ws;
      row.want.total_count = wc;
      dir_rows.push_back(row);
   endtask

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
         errors++;
      end
   endtask

   initial begin
      forever #10 clock = ~clock;
   end

   // sender: one item offered at a time, held until accepted
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            model_rsp = serve_request(req_item);
            expected_rsps.push_back(cur_typed ? cur_want : model_rsp);
            n_sent++;
         end
         if (!req_valid || !req_stall) begin
            if (pending_reqs.size() > 0 &&
                ((n_sent >= 900 && n_sent < 1200) || $urandom_range(99) >= 9)) begin
               req_item  <= pending_reqs[0].item;
               cur_typed  = pending_reqs[0].typed;
               cur_want   = pending_reqs[0].want;
               void'(pending_reqs.pop_front());
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver: random stalls, one long hold-off, checks against oldest expectation
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsps.size() == 0) begin
               $display("%0t: unexpected item: expected none, actual %h/%0d/%0d", $time,
                        rsp_item.popped_value, rsp_item.status, rsp_item.total_count);
               errors++;
            end else begin
               got_want = expected_rsps.pop_front();
               check_field("popped_value", got_want.popped_value, rsp_item.popped_value);
               check_field("status", 32'(got_want.status), 32'(rsp_item.status));
               check_field("total_count", 32'(got_want.total_count), 32'(rsp_item.total_count));
            end
            n_rcvd++;
            if (n_rcvd == 400) hold_left = 200;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (n_rcvd >= 900 && n_rcvd < 1200) begin
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= ($urandom_range(99) < 9);
         end
      end
   end

   initial begin
      plan_entry_type e;
      int             k;
      int             kind;
      int             seg_len;
      int             seg_level;
      int             roll;
      int             n_rand;
      int             push_pct;

      // empty pops, bad priorities, reserved op, value extremes, level order
      add_row(OP_POP_FWD, 32'h0, 8'd0, 1, 1, 32'h0, ST_EMPTY, 8'd0);
      add_row(OP_POP_REV, 32'h0, 8'd0, 1, 1, 32'h0, ST_EMPTY, 8'd0);
      add_row(OP_PUSH, 32'd123, 8'd8, 1, 1, 32'h0, ST_BADPRI, 8'd0);
      add_row(OP_PUSH, 32'hFFFF_FFFF, 8'd255, 1, 1, 32'h0, ST_BADPRI, 8'd0);
      add_row(OP_RESERVED, 32'hDEAD_BEEF, 8'd0, 1, 1, 32'h0, ST_BADPRI, 8'd0);
      add_row(OP_PUSH, 32'h7FFF_FFFF, 8'd0, 1, 1, 32'h0, ST_OK, 8'd1);
      add_row(OP_PUSH, 32'h8000_0000, 8'd7, 1, 1, 32'h0, ST_OK, 8'd2);
      add_row(OP_PUSH, 32'hFFFF_FFFF, 8'd3, 1, 1, 32'h0, ST_OK, 8'd3);
      add_row(OP_PUSH, 32'h0, 8'd3, 1, 1, 32'h0, ST_OK, 8'd4);
      add_row(OP_POP_FWD, 32'h0, 8'd0, 1, 1, 32'h7FFF_FFFF, ST_OK, 8'd3);
      add_row(OP_POP_REV, 32'h0, 8'd0, 1, 1, 32'h8000_0000, ST_OK, 8'd2);
      add_row(OP_POP_REV, 32'h0, 8'd0, 1, 1, 32'hFFFF_FFFF, ST_OK, 8'd1);
      add_row(OP_POP_FWD, 32'h0, 8'd0, 1, 1, 32'h0, ST_OK, 8'd0);
      add_row(OP_POP_FWD, 32'h0, 8'd0, 1, 1, 32'h0, ST_EMPTY, 8'd0);
      // fill one level, then overflow it
      add_row(OP_PUSH, 32'h5000, 8'd5, DEPTH, 0, 32'h0, ST_OK, 8'd0);
      add_row(OP_PUSH, 32'h5555, 8'd5, 1, 1, 32'h0, ST_FULL, 8'(DEPTH));
      add_row(OP_RESERVED, 32'h1, 8'd255, 1, 1, 32'h0, ST_BADPRI, 8'(DEPTH));
      add_row(OP_PUSH, 32'h1234, 8'd4, 1, 0, 32'h0, ST_OK, 8'd0);
      add_row(OP_POP_FWD, 32'h0, 8'd0, 1, 0, 32'h0, ST_OK, 8'd0);

      foreach (dir_rows[i]) begin
         for (k = 0; k < dir_rows[i].reps; k++) begin
            e.item.op = dir_rows[i].op;
            e.item.item_value = dir_rows[i].value + k;
            e.item.priority_level = dir_rows[i].level;
            e.typed = dir_rows[i].typed;
            e.want = dir_rows[i].want;
            pending_reqs.push_back(e);
         end
      end

      // random segments: fill, drain, mixed, single-level hammer, plus noise
      n_rand = 0;
      while (n_rand < RANDOM_ITEMS) begin
         kind = $urandom_range(3);
         seg_len = $urandom_range(40, 120);
         seg_level = $urandom_range(LEVELS - 1);
         push_pct = (kind == 0) ? 85 : (kind == 1) ? 15 : (kind == 2) ? 50 : 70;
         for (k = 0; k < seg_len; k++) begin
            e.typed = 1'b0;
            e.want = '0;
            e.item.item_value = $urandom();
            e.item.priority_level = 8'($urandom_range(255));
            roll = $urandom_range(99);
            if (roll < 4) begin
               e.item.op = OP_PUSH;
               e.item.priority_level = 8'($urandom_range(255, LEVELS));
            end else if (roll < 7) begin
               e.item.op = OP_RESERVED;
            end else if ($urandom_range(99) < push_pct) begin
               e.item.op = OP_PUSH;
               e.item.priority_level = (kind == 3) ? 8'(seg_level)
                                                   : 8'($urandom_range(LEVELS - 1));
            end else begin
               e.item.op = $urandom_range(1) ? OP_POP_FWD : OP_POP_REV;
            end
            pending_reqs.push_back(e);
            n_rand++;
         end
      end
      n_planned = pending_reqs.size();

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      while (n_sent < n_planned) @(negedge clock);
      while (expected_rsps.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("Ran %0d requests, %0d responses: %0d pops served, %0d full-level drops,",
               n_sent, n_rcvd, n_ok_pops, n_full);
      $display("%0d invalid-priority or reserved ops, %0d empty pops, peak occupancy %0d.",
               n_badpri, n_empty, peak_total);
      if (errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   initial begin
      #6_000_000;
      $display("timeout: %0d of %0d items sent, %0d responses", n_sent, n_planned, n_rcvd);
      $display("TB_ERROR");
      $finish;
   end

endmodule
